/* rtl/assert_macros.svh */
// assertion macros for the datagram framer
// expects signals clk and arst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/uwdf_pkg.sv */
// types, constants and crc step for the register write datagram framer
// no dependencies
package uwdf_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'h05;
	localparam logic [7:0] WRITE_FLAG  = 8'h80;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam int         FRAME_BYTES = 8;
	localparam int         BODY_BITS   = (FRAME_BYTES - 1) * 8;
	localparam logic [2:0] CRC_SLOT    = 3'(FRAME_BYTES - 1);

	typedef struct packed {
		logic [6:0]  reg_addr;
		logic [31:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} out_item_t;

	// handshake between serializer and output stage
	typedef struct packed {
		logic      valid;
		out_item_t data;
	} byte_stream_t;

	// one byte into the crc, lsb first, register shifts left
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       top;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			top = c[7];
			c = {c[6:0], 1'b0};
			if (top ^ b[k]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/uwdf_serializer.sv */
// frame shift register, byte counter and running crc
// depends on uwdf_pkg
module uwdf_serializer import uwdf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	output logic                 load_ready,
	input  logic [BODY_BITS-1:0] load_body,
	output byte_stream_t         stream,
	input  logic                 stream_ready
);

	logic                 busy_q;
	logic [2:0]           cnt_q;
	logic [BODY_BITS-1:0] shift_q;
	logic [7:0]           crc_q;
	logic                 at_crc;
	logic                 fire;
	logic                 load;

	assign at_crc     = (cnt_q == CRC_SLOT);
	assign fire       = busy_q && stream_ready;
	// a new frame may load while the crc byte leaves
	assign load_ready = !busy_q || (at_crc && stream_ready);
	assign load       = load_valid && load_ready;

	assign stream.valid          = busy_q;
	assign stream.data.tx_byte   = at_crc ? crc_q : shift_q[BODY_BITS-1 -: 8];
	assign stream.data.last_byte = at_crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (fire) begin
			if (at_crc) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= load_body;
			crc_q   <= '0;
		end else if (fire && !at_crc) begin
			shift_q <= {shift_q[BODY_BITS-9:0], 8'h00};
			crc_q   <= crc_feed(crc_q, shift_q[BODY_BITS-1 -: 8]);
		end
	end

endmodule

/* rtl/uwdf_out_stage.sv */
// single-entry output register between serializer and consumer
// depends on uwdf_pkg
module uwdf_out_stage import uwdf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  byte_stream_t up,
	output logic         up_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output out_item_t    out_data
);

	logic      valid_q;
	out_item_t data_q;

	assign up_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			data_q <= up.data;
		end
	end

endmodule

/* rtl/uwdf_top_placeholder_unused.sv */
// frame builder: packs the seven body bytes of one write datagram
// depends on uwdf_pkg
module uwdf_frame_build import uwdf_pkg::*; (
	input  logic [7:0]           node_address,
	input  in_item_t             item,
	output logic [BODY_BITS-1:0] body
);

	// sync, node, write flag with address, data msb first
	assign body = {SYNC_BYTE, node_address, WRITE_FLAG | {1'b0, item.reg_addr},
		item.write_data};

endmodule

/* rtl/uart_write_datagram_crc8_framer.sv */
// top level of the register write datagram framer
// depends on uwdf_pkg, uwdf_frame_build, uwdf_serializer, uwdf_out_stage, assert_macros.svh
//
// channel   direction  handshake                payload
// in        input      in_valid / in_ready      in_data    (reg_addr, write_data)
// out       output     out_valid / out_ready    out_data   (tx_byte, last_byte)
// cfg       input      cfg_valid / cfg_ready    cfg_data   (node_address)
//
// each request gives eight bytes, one per cycle while out is not stalled;
// the serializer's byte counter steps through them, and the next request
// loads in the cycle the crc byte leaves. results pass from the serializer
// registers through the output register. reset clears the node address to
// zero and empties the pipeline. a stall on out holds the output register
// and freezes the serializer; cfg_ready is always high.
`include "assert_macros.svh"

module uart_write_datagram_crc8_framer import uwdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0]           node_address_q;
	logic [BODY_BITS-1:0] body;
	byte_stream_t         ser_stream;
	logic                 ser_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= '0;
		end else if (cfg_valid) begin
			node_address_q <= cfg_data;
		end
	end

	uwdf_frame_build u_build (
		.node_address (node_address_q),
		.item         (in_data),
		.body         (body)
	);

	uwdf_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (in_valid),
		.load_ready   (in_ready),
		.load_body    (body),
		.stream       (ser_stream),
		.stream_ready (ser_ready)
	);

	uwdf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up        (ser_stream),
		.up_ready  (ser_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`ASSERT_NEXT(a_sync_first, in_valid && in_ready,
		ser_stream.valid && ser_stream.data.tx_byte == SYNC_BYTE && !ser_stream.data.last_byte,
		"accepted transaction did not start with the sync byte")

	`ASSERT_IMPLIES(a_stall_only_busy, !in_ready, ser_stream.valid,
		"input stalled while the serializer is idle")

	`ASSERT_NEXT(a_idle_after_last,
		ser_stream.valid && ser_ready && ser_stream.data.last_byte && !(in_valid && in_ready),
		!ser_stream.valid, "serializer still busy after the crc byte left")

endmodule
